FILE: hdl/kto_pkg.sv
// ----------------------------------------------------------------------------
// kto_pkg
// Shared types, constants and helpers for the keyed table with oldest-entry
// replacement.
// ----------------------------------------------------------------------------
package kto_pkg;

  localparam int ENTRIES = 16;
  localparam int IDX_W   = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
  localparam int CNT_W   = $clog2(ENTRIES + 1);
  localparam int SLOT_W  = 4;
  localparam int KEY_W   = 32;
  localparam int GEN_W   = 32;
  localparam int PALX_W  = 10;
  localparam int PALY_W  = 9;
  localparam int RGB_W   = 24;
  localparam int STAT_W  = 3;

  localparam logic [PALX_W-1:0] PALX_MASK = 10'h3f0;

  localparam logic CMD_LOOKUP = 1'b0;
  localparam logic CMD_INSERT = 1'b1;

  typedef enum logic [STAT_W-1:0] {
    STAT_OK        = 3'd0,
    STAT_NOT_FOUND = 3'd1,
    STAT_BLOCKED   = 3'd2,
    STAT_EXHAUSTED = 3'd3,
    STAT_ZERO_KEY  = 3'd4
  } status_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SCAN,
    ST_DECIDE,
    ST_READ,
    ST_HOLD
  } state_t;

  typedef struct packed {
    logic [KEY_W-1:0] key;
    logic [GEN_W-1:0] gen;
  } key_entry_t;

  typedef struct packed {
    logic [PALX_W-1:0] palx;
    logic [PALY_W-1:0] paly;
    logic [RGB_W-1:0]  upper;
    logic [RGB_W-1:0]  middle;
    logic [RGB_W-1:0]  lower;
  } data_entry_t;

  typedef struct packed {
    logic             rd_en;
    logic [IDX_W-1:0] rd_addr;
    logic             wr_en;
    logic [IDX_W-1:0] wr_addr;
    key_entry_t       wr_data;
  } key_req_t;

  typedef struct packed {
    logic             rd_en;
    logic [IDX_W-1:0] rd_addr;
    logic             wr_en;
    logic [IDX_W-1:0] wr_addr;
    data_entry_t      wr_data;
  } data_req_t;

  // Report only the low bits of a table index.
  function automatic logic [SLOT_W-1:0] to_slot(input logic [IDX_W-1:0] idx);
    logic [IDX_W+SLOT_W-1:0] ext;
    ext = {{SLOT_W{1'b0}}, idx};
    return ext[SLOT_W-1:0];
  endfunction

endpackage

FILE: hdl/kto_if.sv
// ----------------------------------------------------------------------------
// kto_req_if / kto_rsp_if
// Valid/ready channels for table commands and table results.
// ----------------------------------------------------------------------------
interface kto_req_if import kto_pkg::*; ;
  logic              valid;
  logic              ready;
  logic              command;
  logic [KEY_W-1:0]  key;
  logic [PALX_W-1:0] palette_x;
  logic [PALY_W-1:0] palette_y;
  logic [RGB_W-1:0]  upper_rgb;
  logic [RGB_W-1:0]  middle_rgb;
  logic [RGB_W-1:0]  lower_rgb;

  modport source (
    output valid, command, key, palette_x, palette_y, upper_rgb, middle_rgb, lower_rgb,
    input  ready
  );
  modport sink (
    input  valid, command, key, palette_x, palette_y, upper_rgb, middle_rgb, lower_rgb,
    output ready
  );
endinterface

interface kto_rsp_if import kto_pkg::*; ;
  logic              valid;
  logic              ready;
  logic [STAT_W-1:0] status;
  logic [SLOT_W-1:0] slot;
  logic [PALX_W-1:0] out_palette_x;
  logic [PALY_W-1:0] out_palette_y;
  logic [RGB_W-1:0]  out_upper_rgb;
  logic [RGB_W-1:0]  out_middle_rgb;
  logic [RGB_W-1:0]  out_lower_rgb;

  modport source (
    output valid, status, slot, out_palette_x, out_palette_y,
           out_upper_rgb, out_middle_rgb, out_lower_rgb,
    input  ready
  );
  modport sink (
    input  valid, status, slot, out_palette_x, out_palette_y,
           out_upper_rgb, out_middle_rgb, out_lower_rgb,
    output ready
  );
endinterface

FILE: hdl/keyed_table_oldest_replacement.sv
// ----------------------------------------------------------------------------
// keyed_table_oldest_replacement
// Fully associative keyed table with oldest-generation replacement.
// ----------------------------------------------------------------------------
// Usage:
//   in_ch carries one command per transfer: a lookup of a key, or an insert
//   of a key with palette and colors. out_ch returns exactly one result per
//   command, in order. cfg_we/cfg_wdata write the insert-block flag.
//   Each accepted lookup or insert walks the key memory one entry a cycle,
//   then a lookup hit reads the data memory. A refused insert (blocked,
//   generations exhausted, zero key) skips the scan and goes straight to
//   the output register. The next command is taken in the cycle after the
//   previous one is handed to the output register, so the sequential scan
//   of the key memory sets the rate.
//   Reset clears all valid bits, the block flag and sets the generation
//   counter to one; no clearing pass runs. A stalled receiver holds the
//   output register; the block then finishes the next command and waits
//   with its result until the output register frees.
// ----------------------------------------------------------------------------
module keyed_table_oldest_replacement import kto_pkg::*; (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         cfg_we,
  input  logic         cfg_wdata,
  kto_req_if.sink      in_ch,
  kto_rsp_if.source    out_ch
);

  state_t             state_r, state_nxt;
  logic               insert_block_r;
  logic [GEN_W-1:0]   gen_r;
  logic [ENTRIES-1:0] valid_r;

  logic               cmd_r;
  logic [KEY_W-1:0]   key_r;
  data_entry_t        pay_r;

  logic [CNT_W-1:0]   cnt_r;
  logic               eval_vld_r;
  logic [IDX_W-1:0]   eval_idx_r;
  logic               hit_r, free_r, old_r;
  logic [IDX_W-1:0]   hit_idx_r, free_idx_r, old_idx_r;
  logic [GEN_W-1:0]   old_gen_r;

  status_t            res_status_r;
  logic [SLOT_W-1:0]  res_slot_r;
  data_entry_t        res_data_r;

  logic               out_valid_r;
  status_t            out_status_r;
  logic [SLOT_W-1:0]  out_slot_r;
  data_entry_t        out_data_r;

  logic               in_fire;
  logic               refused;
  status_t            refuse_status;
  logic               issue;
  logic               scan_last;
  logic               ent_valid;
  logic               ent_match;
  logic               ent_older;
  logic [IDX_W-1:0]   target_idx;
  logic               load_out;
  key_req_t           key_req;
  data_req_t          data_req;
  key_entry_t         key_rdata;
  data_entry_t        data_rdata;

  kto_key_mem u_key_mem (
    .clk   (clk),
    .req   (key_req),
    .rdata (key_rdata)
  );

  kto_data_mem u_data_mem (
    .clk   (clk),
    .req   (data_req),
    .rdata (data_rdata)
  );

  // Refusal checks in priority order.
  always_comb begin
    refused       = 1'b0;
    refuse_status = STAT_OK;
    if (in_ch.command == CMD_INSERT) begin
      if (insert_block_r) begin
        refused       = 1'b1;
        refuse_status = STAT_BLOCKED;
      end else if (gen_r == '0) begin
        refused       = 1'b1;
        refuse_status = STAT_EXHAUSTED;
      end else if (in_ch.key == '0) begin
        refused       = 1'b1;
        refuse_status = STAT_ZERO_KEY;
      end
    end
  end

  assign in_fire   = in_ch.valid && in_ch.ready;
  assign ent_valid = valid_r[eval_idx_r];
  assign ent_match = eval_vld_r && ent_valid && (key_rdata.key == key_r);
  assign ent_older = eval_vld_r && ent_valid && (!old_r || (key_rdata.gen < old_gen_r));
  assign scan_last = eval_vld_r && !issue;
  assign target_idx = hit_r ? hit_idx_r : (free_r ? free_idx_r : old_idx_r);

  // Next state.
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE: begin
        if (in_fire) begin
          state_nxt = refused ? ST_HOLD : ST_SCAN;
        end
      end
      ST_SCAN: begin
        if (scan_last) begin
          state_nxt = ST_DECIDE;
        end
      end
      ST_DECIDE: begin
        state_nxt = (cmd_r == CMD_LOOKUP && hit_r) ? ST_READ : ST_HOLD;
      end
      ST_READ: begin
        state_nxt = ST_HOLD;
      end
      ST_HOLD: begin
        if (load_out) begin
          state_nxt = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  // State outputs: handshake and memory ports.
  always_comb begin
    in_ch.ready      = 1'b0;
    issue            = 1'b0;
    load_out         = 1'b0;
    key_req.rd_en    = 1'b0;
    key_req.rd_addr  = cnt_r[IDX_W-1:0];
    key_req.wr_en    = 1'b0;
    key_req.wr_addr  = target_idx;
    key_req.wr_data  = '{key: key_r, gen: gen_r};
    data_req.rd_en   = 1'b0;
    data_req.rd_addr = hit_idx_r;
    data_req.wr_en   = 1'b0;
    data_req.wr_addr = target_idx;
    data_req.wr_data = pay_r;
    unique case (state_r)
      ST_IDLE: begin
        in_ch.ready = 1'b1;
      end
      ST_SCAN: begin
        issue         = (cnt_r < CNT_W'(ENTRIES));
        key_req.rd_en = issue;
      end
      ST_DECIDE: begin
        key_req.wr_en  = (cmd_r == CMD_INSERT);
        data_req.wr_en = (cmd_r == CMD_INSERT);
        data_req.rd_en = (cmd_r == CMD_LOOKUP) && hit_r;
      end
      ST_READ: begin
        load_out = 1'b0;
      end
      ST_HOLD: begin
        load_out = !out_valid_r || out_ch.ready;
      end
      default: begin
        in_ch.ready = 1'b0;
      end
    endcase
  end

  // Control state.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r        <= ST_IDLE;
      insert_block_r <= 1'b0;
      gen_r          <= GEN_W'(1);
      valid_r        <= '0;
      cnt_r          <= '0;
      eval_vld_r     <= 1'b0;
      hit_r          <= 1'b0;
      free_r         <= 1'b0;
      old_r          <= 1'b0;
      out_valid_r    <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (cfg_we) begin
        insert_block_r <= cfg_wdata;
      end
      if (in_fire) begin
        cnt_r      <= '0;
        eval_vld_r <= 1'b0;
        hit_r      <= 1'b0;
        free_r     <= 1'b0;
        old_r      <= 1'b0;
      end
      if (state_r == ST_SCAN) begin
        eval_vld_r <= issue;
        if (issue) begin
          cnt_r <= cnt_r + CNT_W'(1);
        end
        if (ent_match) begin
          hit_r <= 1'b1;
        end
        if (eval_vld_r && !ent_valid) begin
          free_r <= 1'b1;
        end
        if (ent_older) begin
          old_r <= 1'b1;
        end
      end
      if (key_req.wr_en) begin
        valid_r[target_idx] <= 1'b1;
        gen_r               <= gen_r + GEN_W'(1);
      end
      if (load_out) begin
        out_valid_r <= 1'b1;
      end else if (out_ch.ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // Payload and scan bookkeeping.
  always_ff @(posedge clk) begin
    if (in_fire) begin
      cmd_r        <= in_ch.command;
      key_r        <= in_ch.key;
      pay_r.palx   <= in_ch.palette_x & PALX_MASK;
      pay_r.paly   <= in_ch.palette_y;
      pay_r.upper  <= in_ch.upper_rgb;
      pay_r.middle <= in_ch.middle_rgb;
      pay_r.lower  <= in_ch.lower_rgb;
      res_status_r <= refuse_status;
      res_slot_r   <= '0;
      res_data_r   <= '0;
    end
    if (issue) begin
      eval_idx_r <= cnt_r[IDX_W-1:0];
    end
    if (ent_match && !hit_r) begin
      hit_idx_r <= eval_idx_r;
    end
    if (eval_vld_r && !ent_valid && !free_r) begin
      free_idx_r <= eval_idx_r;
    end
    if (ent_older) begin
      old_idx_r <= eval_idx_r;
      old_gen_r <= key_rdata.gen;
    end
    if (state_r == ST_DECIDE) begin
      if (cmd_r == CMD_INSERT) begin
        res_status_r <= STAT_OK;
        res_slot_r   <= to_slot(target_idx);
        res_data_r   <= pay_r;
      end else if (!hit_r) begin
        res_status_r <= STAT_NOT_FOUND;
        res_slot_r   <= '0;
        res_data_r   <= '0;
      end
    end
    if (state_r == ST_READ) begin
      res_status_r <= STAT_OK;
      res_slot_r   <= to_slot(hit_idx_r);
      res_data_r   <= data_rdata;
    end
    if (load_out) begin
      out_status_r <= res_status_r;
      out_slot_r   <= res_slot_r;
      out_data_r   <= res_data_r;
    end
  end

  assign out_ch.valid          = out_valid_r;
  assign out_ch.status         = out_status_r;
  assign out_ch.slot           = out_slot_r;
  assign out_ch.out_palette_x  = out_data_r.palx;
  assign out_ch.out_palette_y  = out_data_r.paly;
  assign out_ch.out_upper_rgb  = out_data_r.upper;
  assign out_ch.out_middle_rgb = out_data_r.middle;
  assign out_ch.out_lower_rgb  = out_data_r.lower;

  // The generation counter only ever advances by one.
  assert property (@(posedge clk) disable iff (!rst_n)
    ($past(rst_n) && (gen_r != $past(gen_r))) |-> (gen_r == $past(gen_r) + GEN_W'(1)))
    else $error("generation counter jumped");

  // Valid bits are never dropped outside reset.
  assert property (@(posedge clk) disable iff (!rst_n)
    $past(rst_n) |-> ((valid_r & $past(valid_r)) == $past(valid_r)))
    else $error("table entry lost its valid bit");

  // An insert writes exactly one new valid bit at most, and only alongside a counter step.
  assert property (@(posedge clk) disable iff (!rst_n)
    ($past(rst_n) && (valid_r != $past(valid_r))) |->
      (($countones(valid_r ^ $past(valid_r)) == 1) && (gen_r != $past(gen_r))))
    else $error("valid bits changed without an insert");

  // Key memory is written only after the scan, never while it is being read.
  assert property (@(posedge clk) disable iff (!rst_n)
    key_req.wr_en |-> ((state_r == ST_DECIDE) && !key_req.rd_en))
    else $error("key memory write overlaps the scan");

  // A finished result is never overwritten while it waits in the output register.
  assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && !out_ch.ready) |=> (out_valid_r && $stable(out_data_r)))
    else $error("pending result overwritten");

endmodule

FILE: hdl/kto_key_mem.sv
// ----------------------------------------------------------------------------
// kto_key_mem
// Key and write-generation store, one write and one registered read a cycle.
// ----------------------------------------------------------------------------
module kto_key_mem import kto_pkg::*; (
  input  logic       clk,
  input  key_req_t   req,
  output key_entry_t rdata
);

  key_entry_t mem [ENTRIES];
  key_entry_t rdata_r;

  always_ff @(posedge clk) begin
    if (req.wr_en) begin
      mem[req.wr_addr] <= req.wr_data;
    end
    if (req.rd_en) begin
      rdata_r <= mem[req.rd_addr];
    end
  end

  assign rdata = rdata_r;

endmodule

FILE: hdl/kto_data_mem.sv
// ----------------------------------------------------------------------------
// kto_data_mem
// Palette and color store, one write and one registered read a cycle.
// ----------------------------------------------------------------------------
module kto_data_mem import kto_pkg::*; (
  input  logic        clk,
  input  data_req_t   req,
  output data_entry_t rdata
);

  data_entry_t mem [ENTRIES];
  data_entry_t rdata_r;

  always_ff @(posedge clk) begin
    if (req.wr_en) begin
      mem[req.wr_addr] <= req.wr_data;
    end
    if (req.rd_en) begin
      rdata_r <= mem[req.rd_addr];
    end
  end

  assign rdata = rdata_r;

endmodule

FILE: tb/sv/keyed_table_oldest_replacement_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// keyed_table_oldest_replacement_tb
// Drives lookups and inserts into the keyed table and checks every result
// against a cycle-free table model kept in the testbench. A short directed
// run covers empty-table misses, zero keys, overwrite, fill and oldest-entry
// eviction, and the block flag. Random runs then use a small key pool so hits,
// overwrites and evictions stay frequent, under several idle/stall mixes.
// ----------------------------------------------------------------------------
module keyed_table_oldest_replacement_tb;
  import kto_pkg::*;

  localparam int POOL_SIZE    = 24;
  localparam int DRAIN_CYCLES = 25;

  typedef struct {
    logic              command;
    logic [KEY_W-1:0]  key;
    logic [PALX_W-1:0] palette_x;
    logic [PALY_W-1:0] palette_y;
    logic [RGB_W-1:0]  upper_rgb;
    logic [RGB_W-1:0]  middle_rgb;
    logic [RGB_W-1:0]  lower_rgb;
  } table_cmd_t;

  typedef struct {
    status_t           status;
    logic [SLOT_W-1:0] slot;
    logic [PALX_W-1:0] palx;
    logic [PALY_W-1:0] paly;
    logic [RGB_W-1:0]  upper;
    logic [RGB_W-1:0]  middle;
    logic [RGB_W-1:0]  lower;
  } table_res_t;

  logic clk;
  logic rst_n;
  logic cfg_we;
  logic cfg_wdata;

  kto_req_if cmd_if ();
  kto_rsp_if res_if ();

  keyed_table_oldest_replacement u_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata),
    .in_ch     (cmd_if),
    .out_ch    (res_if)
  );

  // Table model state
  bit                tbl_valid  [ENTRIES];
  logic [KEY_W-1:0]  tbl_key    [ENTRIES];
  logic [GEN_W-1:0]  tbl_gen    [ENTRIES];
  logic [PALX_W-1:0] tbl_palx   [ENTRIES];
  logic [PALY_W-1:0] tbl_paly   [ENTRIES];
  logic [RGB_W-1:0]  tbl_upper  [ENTRIES];
  logic [RGB_W-1:0]  tbl_middle [ENTRIES];
  logic [RGB_W-1:0]  tbl_lower  [ENTRIES];
  logic [GEN_W-1:0]  gen_counter = 1;
  bit                insert_block_copy = 1'b0;

  table_cmd_t       pending_cmds [$];
  table_res_t       expected_results [$];
  table_cmd_t       cur_cmd;
  table_cmd_t       next_cmd;
  logic [KEY_W-1:0] key_pool [POOL_SIZE];

  int send_idle_pct  = 0;
  int recv_stall_pct = 0;
  int mismatches     = 0;
  int transfers_in   = 0;
  int results_seen   = 0;
  int lookup_hits    = 0;
  int lookup_misses  = 0;
  int inserts_done   = 0;
  int evictions      = 0;
  int inserts_refused = 0;

  initial clk = 1'b0;
  always #10 clk = ~clk;

  // Apply one command to the table model and return the result it produces.
  function automatic table_res_t apply_table_cmd(input table_cmd_t c);
    table_res_t r;
    int hit_idx;
    int free_idx;
    int oldest_idx;
    int idx;
    r.status = STAT_OK;
    r.slot   = '0;
    r.palx   = '0;
    r.paly   = '0;
    r.upper  = '0;
    r.middle = '0;
    r.lower  = '0;
    hit_idx    = -1;
    free_idx   = -1;
    oldest_idx = -1;
    for (int i = 0; i < ENTRIES; i++) begin
      if (tbl_valid[i] && tbl_key[i] == c.key && hit_idx < 0) hit_idx = i;
      if (!tbl_valid[i] && free_idx < 0) free_idx = i;
      if (tbl_valid[i] && (oldest_idx < 0 || tbl_gen[i] < tbl_gen[oldest_idx]))
        oldest_idx = i;
    end
    idx = hit_idx;
    if (c.command == CMD_LOOKUP) begin
      if (hit_idx < 0) begin
        r.status = STAT_NOT_FOUND;
        lookup_misses++;
        return r;
      end
      lookup_hits++;
    end else begin
      // Refusal checks go in priority order: block flag, counter wrap, zero key.
      if (insert_block_copy) r.status = STAT_BLOCKED;
      else if (gen_counter == '0) r.status = STAT_EXHAUSTED;
      else if (c.key == '0) r.status = STAT_ZERO_KEY;
      if (r.status != STAT_OK) begin
        inserts_refused++;
        return r;
      end
      if (idx < 0) idx = free_idx;
      if (idx < 0) begin
        idx = oldest_idx;
        evictions++;
      end
      tbl_valid[idx]  = 1'b1;
      tbl_key[idx]    = c.key;
      tbl_gen[idx]    = gen_counter;
      tbl_palx[idx]   = c.palette_x & PALX_MASK;
      tbl_paly[idx]   = c.palette_y;
      tbl_upper[idx]  = c.upper_rgb;
      tbl_middle[idx] = c.middle_rgb;
      tbl_lower[idx]  = c.lower_rgb;
      gen_counter     = gen_counter + 1'b1;
      inserts_done++;
    end
    r.slot   = idx[SLOT_W-1:0];
    r.palx   = tbl_palx[idx];
    r.paly   = tbl_paly[idx];
    r.upper  = tbl_upper[idx];
    r.middle = tbl_middle[idx];
    r.lower  = tbl_lower[idx];
    return r;
  endfunction

  function automatic void check_field(input string name, input logic [31:0] want,
                                      input logic [31:0] got);
    if (got !== want) begin
      $error("%s: expected 0x%0h, got 0x%0h", name, want, got);
      mismatches++;
    end
  endfunction

  function automatic table_cmd_t random_cmd();
    table_cmd_t c;
    int sel;
    sel = $urandom_range(99);
    c.command = ($urandom_range(99) < 55) ? CMD_INSERT : CMD_LOOKUP;
    if (sel < 80) c.key = key_pool[$urandom_range(POOL_SIZE - 1)];
    else if (sel < 90) c.key = $urandom;
    else if (sel < 95) c.key = '0;
    else c.key = '1;
    c.palette_x  = PALX_W'($urandom_range(1023));
    c.palette_y  = PALY_W'($urandom_range(511));
    c.upper_rgb  = RGB_W'($urandom_range(24'hffffff));
    c.middle_rgb = RGB_W'($urandom_range(24'hffffff));
    c.lower_rgb  = RGB_W'($urandom_range(24'hffffff));
    return c;
  endfunction

  // Driver: hold the command until it transfers, then take the next one.
  always @(posedge clk) begin
    if (!rst_n) begin
      cmd_if.valid <= 1'b0;
    end else begin
      if (cmd_if.valid && cmd_if.ready) begin
        expected_results.push_back(apply_table_cmd(cur_cmd));
        transfers_in++;
      end
      if (!cmd_if.valid || cmd_if.ready) begin
        if (pending_cmds.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
          next_cmd = pending_cmds.pop_front();
          cur_cmd  = next_cmd;
          cmd_if.valid      <= 1'b1;
          cmd_if.command    <= next_cmd.command;
          cmd_if.key        <= next_cmd.key;
          cmd_if.palette_x  <= next_cmd.palette_x;
          cmd_if.palette_y  <= next_cmd.palette_y;
          cmd_if.upper_rgb  <= next_cmd.upper_rgb;
          cmd_if.middle_rgb <= next_cmd.middle_rgb;
          cmd_if.lower_rgb  <= next_cmd.lower_rgb;
        end else begin
          cmd_if.valid <= 1'b0;
        end
      end
    end
  end

  // Monitor: compare each result transfer with the oldest expectation.
  always @(posedge clk) begin
    if (!rst_n) begin
      res_if.ready <= 1'b0;
    end else begin
      if (res_if.valid && res_if.ready) begin
        results_seen++;
        if (expected_results.size() == 0) begin
          $error("result with no command outstanding: status 0x%0h slot 0x%0h",
                 res_if.status, res_if.slot);
          mismatches++;
        end else begin
          table_res_t want;
          want = expected_results.pop_front();
          check_field("status", 32'(want.status), 32'(res_if.status));
          check_field("slot", 32'(want.slot), 32'(res_if.slot));
          check_field("out_palette_x", 32'(want.palx), 32'(res_if.out_palette_x));
          check_field("out_palette_y", 32'(want.paly), 32'(res_if.out_palette_y));
          check_field("out_upper_rgb", 32'(want.upper), 32'(res_if.out_upper_rgb));
          check_field("out_middle_rgb", 32'(want.middle), 32'(res_if.out_middle_rgb));
          check_field("out_lower_rgb", 32'(want.lower), 32'(res_if.out_lower_rgb));
        end
      end
      res_if.ready <= ($urandom_range(99) >= recv_stall_pct);
    end
  end

  task automatic add_cmd(input logic command, input logic [KEY_W-1:0] key,
                         input logic [PALX_W-1:0] px, input logic [PALY_W-1:0] py,
                         input logic [RGB_W-1:0] u, input logic [RGB_W-1:0] m,
                         input logic [RGB_W-1:0] l);
    table_cmd_t c;
    c.command    = command;
    c.key        = key;
    c.palette_x  = px;
    c.palette_y  = py;
    c.upper_rgb  = u;
    c.middle_rgb = m;
    c.lower_rgb  = l;
    pending_cmds.push_back(c);
  endtask

  // Wait until every command has transferred and every result has come back.
  task automatic drain();
    while (pending_cmds.size() != 0 || cmd_if.valid || expected_results.size() != 0)
      @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic set_insert_block(input bit value);
    drain();
    @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_wdata <= value;
    insert_block_copy = value;
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  task automatic run_random(input int n, input int send_pct, input int stall_pct);
    drain();
    send_idle_pct  <= send_pct;
    recv_stall_pct <= stall_pct;
    @(posedge clk);
    repeat (n) pending_cmds.push_back(random_cmd());
  endtask

  initial begin
    rst_n     = 1'b0;
    cfg_we    = 1'b0;
    cfg_wdata = 1'b0;
    cmd_if.valid      = 1'b0;
    cmd_if.command    = CMD_LOOKUP;
    cmd_if.key        = '0;
    cmd_if.palette_x  = '0;
    cmd_if.palette_y  = '0;
    cmd_if.upper_rgb  = '0;
    cmd_if.middle_rgb = '0;
    cmd_if.lower_rgb  = '0;
    res_if.ready      = 1'b0;
    for (int i = 0; i < POOL_SIZE; i++) begin
      key_pool[i] = $urandom;
      if (key_pool[i] == '0) key_pool[i] = 32'h1;
    end

    repeat (7) @(posedge clk);
    rst_n <= 1'b1;

    // Empty table, zero keys, then all-ones payload and masked palette x.
    add_cmd(CMD_LOOKUP, '1, '0, '0, '0, '0, '0);
    add_cmd(CMD_LOOKUP, '0, '0, '0, '0, '0, '0);
    add_cmd(CMD_INSERT, '0, 10'h3ff, 9'h1ff, 24'hffffff, 24'hffffff, 24'hffffff);
    add_cmd(CMD_INSERT, '1, 10'h3ff, 9'h1ff, 24'hffffff, 24'hffffff, 24'hffffff);
    add_cmd(CMD_LOOKUP, '1, '0, '0, '0, '0, '0);
    add_cmd(CMD_INSERT, 32'h1, '0, '0, '0, '0, '0);
    // Overwrite makes slot 0 the newest, so key 1 becomes the oldest entry.
    add_cmd(CMD_INSERT, '1, 10'h00f, 9'h0aa, 24'h123456, 24'h789abc, 24'hdef012);
    for (int i = 2; i < ENTRIES; i++)
      add_cmd(CMD_INSERT, 32'h0100_0000 * (i + 1) + 32'h5a5a,
              PALX_W'($urandom_range(1023)), PALY_W'($urandom_range(511)),
              RGB_W'($urandom_range(24'hffffff)), RGB_W'($urandom_range(24'hffffff)),
              RGB_W'($urandom_range(24'hffffff)));
    add_cmd(CMD_INSERT, 32'h8000_0000, 10'h2a5, 9'h155, 24'h0000ff, 24'h00ff00, 24'hff0000);
    add_cmd(CMD_LOOKUP, 32'h1, '0, '0, '0, '0, '0);

    // Blocked inserts, including a zero key, while lookups still hit.
    set_insert_block(1'b1);
    add_cmd(CMD_INSERT, 32'h8000_0001, 10'h3ff, 9'h1ff, 24'h1, 24'h2, 24'h3);
    add_cmd(CMD_INSERT, '0, '0, '0, '0, '0, '0);
    add_cmd(CMD_LOOKUP, 32'h8000_0000, '0, '0, '0, '0, '0);
    set_insert_block(1'b0);

    run_random(100, 0, 0);
    run_random(100, 61, 0);
    run_random(100, 0, 61);
    run_random(100, 21, 21);
    set_insert_block(1'b1);
    run_random(40, 21, 21);
    set_insert_block(1'b0);
    run_random(60, 0, 0);
    drain();

    $display("Checked %0d results for %0d commands: %0d lookup hits, %0d misses.",
             results_seen, transfers_in, lookup_hits, lookup_misses);
    $display("%0d inserts written with %0d evictions, %0d refused; block flag 0 and 1.",
             inserts_done, evictions, inserts_refused);
    if (mismatches == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

  initial begin
    #10_000_000;
    $display("timeout with %0d results outstanding", expected_results.size());
    $display("simulation failed");
    $finish;
  end

endmodule
